[rtl/core/bcl_pkg.sv]
// shared types and codes of the block cache lru controller
package bcl_pkg;

   localparam logic [2:0] KIND_READ  = 3'd0;
   localparam logic [2:0] KIND_GET   = 3'd1;
   localparam logic [2:0] KIND_PUT   = 3'd2;
   localparam logic [2:0] KIND_DIRTY = 3'd3;
   localparam logic [2:0] KIND_ZERO  = 3'd4;
   localparam logic [2:0] KIND_FLUSH = 3'd5;

   localparam logic [1:0] ACT_DONE  = 2'd0;
   localparam logic [1:0] ACT_WB    = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;
   localparam logic [1:0] ACT_ERROR = 2'd3;

   localparam logic [7:0] PIN_MAX = 8'd255;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_EVICT,
      S_ALLOC,
      S_FLUSH,
      S_FLUSH_END
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HIT,
      OP_ERR,
      OP_WB_VICTIM,
      OP_ALLOC_FREE,
      OP_ALLOC_VICTIM,
      OP_FLUSH_WB,
      OP_FLUSH_DONE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
      logic   scan_clr;
      logic   scan_step;
      logic   rank_clr;
      logic   rank_step;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       hit;
      logic       full;
      logic       out_free;
      logic       scan_last;
      logic       best_valid;
      logic       best_dirty;
      logic       rank_done;
      logic       rank_dirty;
   } sts_type;

endpackage

[rtl/core/block_cache_lru_controller_unit.sv]
// top level of the block cache lru controller
//
// channel  direction  payload
// req      in         tuser: kind, tdata: block_number
// rsp      out        tuser: action, hit, tdata: slot, target_block, tlast: last
//
// one request at a time; hit, error and free-entry miss are answered from the decide state
// a miss with all entries in use first scans every entry for the least recently used unpinned victim
// flush walks the used entries in recency order, writes back each dirty one, then ends with a done result
// any step that issues a result waits while the rsp register is still full
// the rsp register lets the next request enter while a result waits
// reset (synchronous) frees all entries
module block_cache_lru_controller_unit import bcl_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // block_number[31:0]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // slot[3:0], target_block[35:4], zero[39:36]
   output logic [2:0]  rsp_tuser,   // action[1:0], hit[2]
   output logic        rsp_tlast
);

   cmd_type     cmd;
   sts_type     sts;
   logic [1:0]  action;
   logic [3:0]  slot;
   logic [31:0] target;
   logic        hit;

   bcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcl_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_block  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_action (action),
      .rsp_slot   (slot),
      .rsp_target (target),
      .rsp_hit    (hit),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, target, slot};
   assign rsp_tuser = {hit, action};

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_NONE) |-> sts.out_free)
      else $error("result issued while output register full");

   a_idle_no_op: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (cmd.op == OP_NONE))
      else $error("result issued while accepting a request");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_NONE) |=> rsp_tvalid)
      else $error("issued result not presented");

endmodule

[rtl/core/bcl_ctrl.sv]
// controller state machine of the block cache lru controller
module bcl_ctrl import bcl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.kind == KIND_FLUSH) begin
               state_in = S_FLUSH;
            end else if (sts.kind > KIND_FLUSH || sts.hit ||
                         sts.kind == KIND_PUT || sts.kind == KIND_DIRTY ||
                         !sts.full) begin
               if (sts.out_free) state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_last) state_in = S_EVICT;
         end
         S_EVICT: begin
            if (!sts.best_valid) begin
               if (sts.out_free) state_in = S_IDLE;
            end else if (!sts.best_dirty || sts.out_free) begin
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_FLUSH: begin
            if (sts.rank_done) state_in = S_FLUSH_END;
         end
         S_FLUSH_END: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.op = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         S_DECIDE: begin
            if (sts.kind == KIND_FLUSH) begin
               cmd.rank_clr = 1'b1;
            end else if (!sts.out_free) begin
               cmd.op = OP_NONE;
            end else if (sts.kind > KIND_FLUSH) begin
               cmd.op = OP_ERR;
            end else if (sts.hit) begin
               cmd.op = OP_HIT;
            end else if (sts.kind == KIND_PUT || sts.kind == KIND_DIRTY) begin
               cmd.op = OP_ERR;
            end else if (!sts.full) begin
               cmd.op = OP_ALLOC_FREE;
            end
            if (sts.kind < KIND_FLUSH && !sts.hit && sts.full &&
                sts.kind != KIND_PUT && sts.kind != KIND_DIRTY) begin
               cmd.scan_clr = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         S_EVICT: begin
            if (sts.out_free) begin
               if (!sts.best_valid) cmd.op = OP_ERR;
               else if (sts.best_dirty) cmd.op = OP_WB_VICTIM;
            end
         end
         S_ALLOC: begin
            if (sts.out_free) cmd.op = OP_ALLOC_VICTIM;
         end
         S_FLUSH: begin
            if (!sts.rank_done) begin
               if (!sts.rank_dirty) begin
                  cmd.rank_step = 1'b1;
               end else if (sts.out_free) begin
                  cmd.op = OP_FLUSH_WB;
                  cmd.rank_step = 1'b1;
               end
            end
         end
         S_FLUSH_END: begin
            if (sts.out_free) cmd.op = OP_FLUSH_DONE;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

[rtl/core/bcl_dp.sv]
// entry state, search logic and result register of the block cache lru controller
module bcl_dp import bcl_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_block,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [3:0]  rsp_slot,
   output logic [31:0] rsp_target,
   output logic        rsp_hit,
   output logic        rsp_last
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   logic [2:0]          kind_ff;
   logic [31:0]         blk_ff;
   logic [31:0]         tag_ff [ENTRIES];
   logic [31:0]         tag_in [ENTRIES];
   logic [ENTRIES-1:0]  use_ff, use_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic [7:0]          pins_ff [ENTRIES];
   logic [7:0]          pins_in [ENTRIES];
   logic [IW-1:0]       rec_ff [ENTRIES];
   logic [IW-1:0]       rec_in [ENTRIES];
   logic [CW-1:0]       used_ff, used_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic                best_v_ff, best_v_in;
   logic [IW-1:0]       best_ff, best_in;
   logic [IW-1:0]       best_rec_ff, best_rec_in;
   logic [CW-1:0]       rank_ff, rank_in;
   logic                out_v_ff, out_v_in;
   logic [1:0]          act_ff, act_in;
   logic [3:0]          slot_ff, slot_in;
   logic [31:0]         tgt_ff, tgt_in;
   logic                hit_ff, hit_in;
   logic                last_ff, last_in;

   logic [ENTRIES-1:0]  hit_vec, rank_vec;
   logic [IW-1:0]       hit_idx, rank_idx, free_idx, mr_idx, alloc_idx;
   logic [IW-1:0]       mr_rec;
   logic                scan_cand, out_free;

   always_comb begin
      hit_idx = '0;
      rank_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = use_ff[i] && (tag_ff[i] == blk_ff);
         rank_vec[i] = use_ff[i] && (rec_ff[i] == rank_ff[IW-1:0]);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_idx = IW'(i);
         if (rank_vec[i]) rank_idx = IW'(i);
      end
   end

   assign free_idx  = IW'(CW'(ENTRIES - 1) - used_ff);
   assign scan_cand = use_ff[scan_ff] && (pins_ff[scan_ff] == 8'd0) &&
                      (!best_v_ff || (rec_ff[scan_ff] < best_rec_ff));
   assign out_free  = !out_v_ff || rsp_ready;
   assign mr_idx    = (cmd.op == OP_HIT) ? hit_idx : best_ff;
   assign mr_rec    = rec_ff[mr_idx];
   assign alloc_idx = (cmd.op == OP_ALLOC_FREE) ? free_idx : best_ff;

   always_comb begin
      sts.kind       = kind_ff;
      sts.hit        = |hit_vec;
      sts.full       = (used_ff == CW'(ENTRIES));
      sts.out_free   = out_free;
      sts.scan_last  = (scan_ff == IW'(ENTRIES - 1));
      sts.best_valid = best_v_ff;
      sts.best_dirty = dirty_ff[best_ff];
      sts.rank_done  = (rank_ff == used_ff);
      sts.rank_dirty = |(rank_vec & dirty_ff);
   end

   always_comb begin
      tag_in   = tag_ff;
      use_in   = use_ff;
      dirty_in = dirty_ff;
      pins_in  = pins_ff;
      rec_in   = rec_ff;
      used_in  = used_ff;
      act_in   = act_ff;
      slot_in  = slot_ff;
      tgt_in   = tgt_ff;
      hit_in   = hit_ff;
      last_in  = last_ff;
      out_v_in = out_v_ff && !rsp_ready;

      if (cmd.op == OP_HIT || cmd.op == OP_ALLOC_VICTIM) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (use_ff[i] && rec_ff[i] > mr_rec) rec_in[i] = rec_ff[i] - 1'b1;
         end
         rec_in[mr_idx] = IW'(used_ff - 1'b1);
      end

      case (cmd.op)
         OP_HIT: begin
            if (kind_ff == KIND_GET && pins_ff[hit_idx] != PIN_MAX) begin
               pins_in[hit_idx] = pins_ff[hit_idx] + 8'd1;
            end else if (kind_ff == KIND_PUT && pins_ff[hit_idx] != 8'd0) begin
               pins_in[hit_idx] = pins_ff[hit_idx] - 8'd1;
            end else if (kind_ff == KIND_DIRTY || kind_ff == KIND_ZERO) begin
               dirty_in[hit_idx] = 1'b1;
            end
            act_in = ACT_DONE; slot_in = 4'(hit_idx); tgt_in = blk_ff;
            hit_in = 1'b1; last_in = 1'b1;
         end
         OP_ERR: begin
            act_in = ACT_ERROR; slot_in = '0; tgt_in = blk_ff;
            hit_in = 1'b0; last_in = 1'b1;
         end
         OP_WB_VICTIM: begin
            dirty_in[best_ff] = 1'b0;
            act_in = ACT_WB; slot_in = 4'(best_ff); tgt_in = tag_ff[best_ff];
            hit_in = 1'b0; last_in = 1'b0;
         end
         OP_ALLOC_FREE, OP_ALLOC_VICTIM: begin
            if (cmd.op == OP_ALLOC_FREE) begin
               use_in[alloc_idx] = 1'b1;
               rec_in[alloc_idx] = IW'(used_ff);
               used_in = used_ff + 1'b1;
            end
            tag_in[alloc_idx]   = blk_ff;
            dirty_in[alloc_idx] = (kind_ff == KIND_ZERO);
            pins_in[alloc_idx]  = (kind_ff == KIND_GET) ? 8'd1 : 8'd0;
            act_in = (kind_ff == KIND_ZERO) ? ACT_DONE : ACT_FILL;
            slot_in = 4'(alloc_idx); tgt_in = blk_ff;
            hit_in = 1'b0; last_in = 1'b1;
         end
         OP_FLUSH_WB: begin
            dirty_in[rank_idx] = 1'b0;
            act_in = ACT_WB; slot_in = 4'(rank_idx); tgt_in = tag_ff[rank_idx];
            hit_in = 1'b0; last_in = 1'b0;
         end
         OP_FLUSH_DONE: begin
            act_in = ACT_DONE; slot_in = '0; tgt_in = '0;
            hit_in = 1'b0; last_in = 1'b1;
         end
         default: begin
         end
      endcase
      if (cmd.op != OP_NONE) out_v_in = 1'b1;
   end

   always_comb begin
      scan_in     = scan_ff;
      best_v_in   = best_v_ff;
      best_in     = best_ff;
      best_rec_in = best_rec_ff;
      rank_in     = rank_ff;
      if (cmd.scan_clr) begin
         scan_in   = '0;
         best_v_in = 1'b0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         if (scan_cand) begin
            best_v_in   = 1'b1;
            best_in     = scan_ff;
            best_rec_in = rec_ff[scan_ff];
         end
      end
      if (cmd.rank_clr) rank_in = '0;
      else if (cmd.rank_step) rank_in = rank_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff    <= '0;
         dirty_ff  <= '0;
         used_ff   <= '0;
         out_v_ff  <= 1'b0;
         best_v_ff <= 1'b0;
         scan_ff   <= '0;
         rank_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            pins_ff[i] <= '0;
            rec_ff[i]  <= '0;
         end
      end else begin
         use_ff    <= use_in;
         dirty_ff  <= dirty_in;
         used_ff   <= used_in;
         out_v_ff  <= out_v_in;
         best_v_ff <= best_v_in;
         scan_ff   <= scan_in;
         rank_ff   <= rank_in;
         pins_ff   <= pins_in;
         rec_ff    <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         blk_ff  <= req_block;
      end
      tag_ff      <= tag_in;
      best_ff     <= best_in;
      best_rec_ff <= best_rec_in;
      act_ff      <= act_in;
      slot_ff     <= slot_in;
      tgt_ff      <= tgt_in;
      hit_ff      <= hit_in;
      last_ff     <= last_in;
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_action = act_ff;
   assign rsp_slot   = slot_ff;
   assign rsp_target = tgt_ff;
   assign rsp_hit    = hit_ff;
   assign rsp_last   = last_ff;

endmodule
